>>> design/pid_controller_clamped_macros.svh
// Assertion shorthands for the PID controller checks.
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PIDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pidc_pkg.sv
package pidc_pkg;

   // command codes carried in req_tuser
   localparam logic [1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [1:0] CMD_CLEAR   = 2'd1;
   localparam logic [1:0] CMD_PRELOAD = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_GAIN_P    = 3'd0;
   localparam logic [2:0] CSR_GAIN_I    = 3'd1;
   localparam logic [2:0] CSR_GAIN_D    = 3'd2;
   localparam logic [2:0] CSR_TIME_STEP = 3'd3;
   localparam logic [2:0] CSR_INT_LOW   = 3'd4;
   localparam logic [2:0] CSR_INT_HIGH  = 3'd5;
   localparam logic [2:0] CSR_DRV_LOW   = 3'd6;
   localparam logic [2:0] CSR_DRV_HIGH  = 3'd7;

   // microcode entry points
   localparam logic [3:0] PC_IDLE    = 4'd0;
   localparam logic [3:0] PC_SAMPLE  = 4'd1;
   localparam logic [3:0] PC_CLEAR   = 4'd7;
   localparam logic [3:0] PC_PRELOAD = 4'd8;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_ERR_DT,
      MUL_P_ERR,
      MUL_D_DELTA,
      MUL_I_INTEG
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD_SH16,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      INT_HOLD,
      INT_SUM,
      INT_CLAMP
   } integ_op_type;

   typedef enum logic [1:0] {
      ST_HOLD,
      ST_CLEAR,
      ST_PRELOAD,
      ST_COMMIT
   } state_op_type;

   typedef struct packed {
      logic         dispatch;
      mul_sel_type  mul_sel;
      acc_op_type   acc_op;
      integ_op_type integ_op;
      state_op_type state_op;
      logic         emit;
      logic [3:0]   next_pc;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      step_en;
      logic      capture;
   } dp_ctrl_type;

   function automatic ucode_type ucode_rom(input logic [3:0] pc);
      ucode_type w;
      unique case (pc)
         4'd1: w = '{1'b0, MUL_ERR_DT,  ACC_CLEAR,    INT_HOLD,  ST_HOLD,    1'b0, 4'd2};
         4'd2: w = '{1'b0, MUL_P_ERR,   ACC_HOLD,     INT_SUM,   ST_HOLD,    1'b0, 4'd3};
         4'd3: w = '{1'b0, MUL_D_DELTA, ACC_ADD_SH16, INT_CLAMP, ST_HOLD,    1'b0, 4'd4};
         4'd4: w = '{1'b0, MUL_I_INTEG, ACC_ADD_SH16, INT_HOLD,  ST_HOLD,    1'b0, 4'd5};
         4'd5: w = '{1'b0, MUL_NONE,    ACC_ADD,      INT_HOLD,  ST_HOLD,    1'b0, 4'd6};
         4'd6: w = '{1'b0, MUL_NONE,    ACC_HOLD,     INT_HOLD,  ST_COMMIT,  1'b1, PC_IDLE};
         4'd7: w = '{1'b0, MUL_NONE,    ACC_HOLD,     INT_HOLD,  ST_CLEAR,   1'b0, PC_IDLE};
         4'd8: w = '{1'b0, MUL_NONE,    ACC_HOLD,     INT_HOLD,  ST_PRELOAD, 1'b0, PC_IDLE};
         default: w = '{1'b1, MUL_NONE, ACC_HOLD,     INT_HOLD,  ST_HOLD,    1'b0, PC_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [3:0] dispatch_pc(input logic [1:0] cmd);
      logic [3:0] pc;
      unique case (cmd)
         CMD_SAMPLE:  pc = PC_SAMPLE;
         CMD_CLEAR:   pc = PC_CLEAR;
         CMD_PRELOAD: pc = PC_PRELOAD;
         default:     pc = PC_IDLE;
      endcase
      return pc;
   endfunction

endpackage

>>> design/pidc_dp.sv
module pidc_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_wdata,
   input  pidc_pkg::dp_ctrl_type     ctrl,
   input  logic signed [15:0]        target,
   input  logic signed [15:0]        measured,
   input  logic signed [31:0]        preload_value,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic signed [15:0]        drive,
   output logic                      out_busy
);
   import pidc_pkg::*;

   localparam logic signed [53:0] ROUND_HALF = 54'sd8388608;

   // configuration
   logic signed [15:0] gain_p_ff, gain_p_in;
   logic signed [15:0] gain_i_ff, gain_i_in;
   logic signed [15:0] gain_d_ff, gain_d_in;
   logic        [15:0] time_step_ff, time_step_in;
   logic signed [31:0] int_low_ff, int_low_in;
   logic signed [31:0] int_high_ff, int_high_in;
   logic signed [15:0] drv_low_ff, drv_low_in;
   logic signed [15:0] drv_high_ff, drv_high_in;

   // controller state
   logic signed [31:0] integral_ff, integral_in;
   logic signed [16:0] prev_err_ff, prev_err_in;
   logic               started_ff, started_in;
   logic               valid_ff, valid_in;

   // working registers
   logic signed [16:0] error_ff, error_in;
   logic signed [31:0] preload_ff, preload_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [34:0] isum_ff, isum_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [53:0] acc_ff, acc_in;
   logic signed [15:0] drive_ff, drive_in;

   logic signed [17:0] delta;
   logic signed [16:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [34:0] ilo, ihi, iclamp;
   logic signed [53:0] rnd;
   logic signed [29:0] quot, dlo, dhi, dclamp;
   logic               en;

   assign en = ctrl.step_en;

   always_comb begin
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      time_step_in = time_step_ff;
      int_low_in   = int_low_ff;
      int_high_in  = int_high_ff;
      drv_low_in   = drv_low_ff;
      drv_high_in  = drv_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:    gain_p_in    = csr_wdata[15:0];
            CSR_GAIN_I:    gain_i_in    = csr_wdata[15:0];
            CSR_GAIN_D:    gain_d_in    = csr_wdata[15:0];
            CSR_TIME_STEP: time_step_in = csr_wdata[15:0];
            CSR_INT_LOW:   int_low_in   = csr_wdata;
            CSR_INT_HIGH:  int_high_in  = csr_wdata;
            CSR_DRV_LOW:   drv_low_in   = csr_wdata[15:0];
            CSR_DRV_HIGH:  drv_high_in  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // derivative is zero on the first sample after a clear
   assign delta = started_ff ? (18'(error_ff) - 18'(prev_err_ff)) : '0;

   always_comb begin
      case (ctrl.word.mul_sel)
         MUL_ERR_DT: begin
            mul_a = error_ff;
            mul_b = {16'b0, time_step_ff};
         end
         MUL_P_ERR: begin
            mul_a = 17'(gain_p_ff);
            mul_b = 32'(error_ff);
         end
         MUL_D_DELTA: begin
            mul_a = 17'(gain_d_ff);
            mul_b = 32'(delta);
         end
         MUL_I_INTEG: begin
            mul_a = 17'(gain_i_ff);
            mul_b = integ_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      ilo    = 35'(int_low_ff);
      ihi    = 35'(int_high_ff);
      iclamp = isum_ff;
      if (iclamp < ilo) iclamp = ilo;
      if (iclamp > ihi) iclamp = ihi;

      // round half up, then take the integer part
      rnd    = acc_ff + ROUND_HALF;
      quot   = rnd[53:24];
      dlo    = 30'(drv_low_ff);
      dhi    = 30'(drv_high_ff);
      dclamp = quot;
      if (dclamp < dlo) dclamp = dlo;
      if (dclamp > dhi) dclamp = dhi;
   end

   always_comb begin
      error_in   = ctrl.capture ? (17'(target) - 17'(measured)) : error_ff;
      preload_in = ctrl.capture ? preload_value : preload_ff;

      prod_in = prod_ff;
      if (en && ctrl.word.mul_sel != MUL_NONE) prod_in = mul_a * mul_b;

      isum_in  = isum_ff;
      integ_in = integ_ff;
      // error*dt is a signed 33 bit value
      if (en && ctrl.word.integ_op == INT_SUM)
         isum_in = 35'(integral_ff) + 35'($signed(prod_ff[33:0]));
      if (en && ctrl.word.integ_op == INT_CLAMP) integ_in = iclamp[31:0];

      acc_in = acc_ff;
      if (en) begin
         case (ctrl.word.acc_op)
            ACC_CLEAR:    acc_in = '0;
            ACC_ADD_SH16: acc_in = acc_ff + $signed({prod_ff[37:0], 16'b0});
            ACC_ADD:      acc_in = acc_ff + 54'(prod_ff);
            default:      acc_in = acc_ff;
         endcase
      end

      drive_in = (en && ctrl.word.emit) ? dclamp[15:0] : drive_ff;
      valid_in = (en && ctrl.word.emit) ? 1'b1 : (valid_ff && !rsp_tready);

      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      started_in  = started_ff;
      if (en) begin
         case (ctrl.word.state_op)
            ST_CLEAR: begin
               integral_in = '0;
               prev_err_in = '0;
               started_in  = 1'b0;
            end
            ST_PRELOAD: integral_in = preload_ff;
            ST_COMMIT: begin
               integral_in = integ_ff;
               prev_err_in = error_ff;
               started_in  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         time_step_ff <= 16'hFFFF;
         int_low_ff   <= 32'sh8000_0000;
         int_high_ff  <= 32'sh7FFF_FFFF;
         drv_low_ff   <= 16'sh8000;
         drv_high_ff  <= 16'sh7FFF;
         integral_ff  <= '0;
         prev_err_ff  <= '0;
         started_ff   <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         time_step_ff <= time_step_in;
         int_low_ff   <= int_low_in;
         int_high_ff  <= int_high_in;
         drv_low_ff   <= drv_low_in;
         drv_high_ff  <= drv_high_in;
         integral_ff  <= integral_in;
         prev_err_ff  <= prev_err_in;
         started_ff   <= started_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      error_ff   <= error_in;
      preload_ff <= preload_in;
      prod_ff    <= prod_in;
      isum_ff    <= isum_in;
      integ_ff   <= integ_in;
      acc_ff     <= acc_in;
      drive_ff   <= drive_in;
   end

   assign rsp_tvalid = valid_ff;
   assign drive      = drive_ff;
   assign out_busy   = valid_ff && !rsp_tready;

endmodule

>>> design/pidc_seq.sv
module pidc_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [1:0]            cmd,
   input  logic                  out_busy,
   output logic                  req_tready,
   output pidc_pkg::dp_ctrl_type ctrl
);
   import pidc_pkg::*;

   logic [3:0] pc_ff, pc_in;
   ucode_type  word;
   logic       step_en;

   assign word    = ucode_rom(pc_ff);
   // the result step waits for a free output register
   assign step_en = !(word.emit && out_busy);

   assign req_tready   = word.dispatch;
   assign ctrl.word    = word;
   assign ctrl.step_en = step_en;
   assign ctrl.capture = word.dispatch && req_tvalid;

   always_comb begin
      if (word.dispatch) begin
         pc_in = req_tvalid ? dispatch_pc(cmd) : pc_ff;
      end else if (step_en) begin
         pc_in = word.next_pc;
      end else begin
         pc_in = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> design/pid_controller_clamped.sv
// Clamped fixed-point PID regulator. Each beat on req_ carries a command in
// tuser: a sample (target, measured) returns one drive beat on rsp_; clear
// and preload change the controller state and return nothing; the unused
// code is dropped. A sample runs 6 microcode steps on one shared 17x32
// multiplier and accumulator, and the block accepts no new beat until its
// last step is done; clear and preload run one step each. The last sample
// step waits while an earlier drive beat is still held in rsp_. The user
// must write registers through csr_ only while the block is idle; the block
// itself does not enforce this.
module pid_controller_clamped (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // target[15:0], measured[31:16], preload_value[63:32]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drive[15:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pidc_pkg::*;

   dp_ctrl_type        ctrl;
   logic               out_busy;
   logic signed [15:0] drive;

   pidc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .cmd        (req_tuser),
      .out_busy   (out_busy),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   pidc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .ctrl          (ctrl),
      .target        (req_tdata[15:0]),
      .measured      (req_tdata[31:16]),
      .preload_value (req_tdata[63:32]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .drive         (drive),
      .out_busy      (out_busy)
   );

   assign rsp_tdata = drive;

endmodule

>>> design/pidc_checker.sv
`include "pid_controller_clamped_macros.svh"

module pidc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import pidc_pkg::*;

   `PIDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "drive beat changed while stalled")
   `PIDC_ASSERT_NEXT(a_busy_after_sample, clock, reset, req_tvalid && req_tready && req_tuser == CMD_SAMPLE, !req_tready, "ready right after a sample")
   `PIDC_ASSERT_NEXT(a_no_early_result, clock, reset, req_tvalid && req_tready && !rsp_tvalid, !rsp_tvalid, "result one cycle after accept")
   `PIDC_ASSERT_SAME(a_result_while_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "result appeared while idle")

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);

>>> verif/pid_controller_clamped_tb.sv
`timescale 1ns / 1ps

module pid_controller_clamped_tb;
   import pidc_pkg::*;

   // code the block drops without a result
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] target;
      logic [15:0] measured;
      logic [31:0] preload;
   } req_beat_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // target[15:0], measured[31:16], preload_value[63:32]
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // drive[15:0]
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pid_controller_clamped i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // controller image: registers and loop state
   logic signed [63:0] kp = 0, ki = 0, kd_dt = 0, dt_q16 = 65535;
   logic signed [63:0] integ_lo = -64'sd2147483648, integ_hi = 64'sd2147483647;
   logic signed [63:0] drv_lo = -64'sd32768, drv_hi = 64'sd32767;
   logic signed [63:0] integ_sum = 0, last_err = 0;
   logic               loop_started = 1'b0;

   req_beat_type pending_q[$];
   logic [15:0]  drive_q[$];
   req_beat_type cur_beat;
   int          beats_queued = 0;
   int          beats_taken = 0;
   int          mismatches = 0;

   int          gap_max = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   logic [31:0] stall_pattern = '1;
   logic [4:0]  pat_pos = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic run_loop(input req_beat_type b);
      logic signed [63:0] err, delta, integ, acc, drv;
      case (b.cmd)
         CMD_CLEAR: begin
            integ_sum = 0;
            last_err = 0;
            loop_started = 1'b0;
         end
         CMD_PRELOAD: integ_sum = $signed(b.preload);
         CMD_SAMPLE: begin
            err = $signed(b.target) - $signed(b.measured);
            delta = loop_started ? err - last_err : 64'sd0;
            integ = integ_sum + err * dt_q16;
            if (integ < integ_lo) integ = integ_lo;
            if (integ > integ_hi) integ = integ_hi;
            acc = kp * err * 65536 + ki * integ + kd_dt * delta * 65536;
            // floor after adding half: rounds half up
            drv = (acc + 64'sd8388608) >>> 24;
            if (drv < drv_lo) drv = drv_lo;
            if (drv > drv_hi) drv = drv_hi;
            integ_sum = integ;
            last_err = err;
            loop_started = 1'b1;
            drive_q.push_back(drv[15:0]);
         end
         default: ;
      endcase
   endtask

   // sender: bursts of beats separated by random gaps
   always @(posedge clock) begin : req_driver
      req_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            run_loop(cur_beat);
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               nxt = pending_q.pop_front();
               cur_beat = nxt;
               req_tvalid <= 1'b1;
               req_tuser <= nxt.cmd;
               req_tdata <= {nxt.preload, nxt.measured, nxt.target};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = $urandom_range(0, gap_max);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: stalls follow a rotating pattern
   always @(posedge clock) begin : rsp_monitor
      logic [15:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               $display("%0t: unexpected drive beat, expected none, actual %0d",
                        $time, $signed(rsp_tdata));
               mismatches++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: drive mismatch, expected %0d, actual %0d",
                           $time, $signed(want), $signed(rsp_tdata));
                  mismatches++;
               end
            end
         end
         rsp_tready <= stall_pattern[pat_pos];
         pat_pos <= pat_pos + 5'd1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic queue_beat(input logic [1:0] cmd, input logic [15:0] tgt,
                             input logic [15:0] meas, input logic [31:0] pre);
      req_beat_type b;
      b.cmd = cmd;
      b.target = tgt;
      b.measured = meas;
      b.preload = pre;
      pending_q.push_back(b);
      beats_queued++;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (beats_taken != beats_queued || drive_q.size() != 0);
      // clear/preload may still be in flight with nothing expected
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            gap_max = 0;
            stall_pattern = '1;
         end
         1: begin
            gap_max = 3;
            stall_pattern = $urandom | 32'h1111_1111;
         end
         default: begin
            gap_max = 10;
            stall_pattern = ($urandom & $urandom) | 32'h1;
         end
      endcase
   endtask

   // writes all eight registers, one per cycle
   task automatic program_regs(input logic [15:0] p, input logic [15:0] i,
                               input logic [15:0] d, input logic [15:0] step,
                               input logic [31:0] ilo, input logic [31:0] ihi,
                               input logic [15:0] dlo, input logic [15:0] dhi);
      logic [31:0] vals[8];
      vals[CSR_GAIN_P] = {16'd0, p};
      vals[CSR_GAIN_I] = {16'd0, i};
      vals[CSR_GAIN_D] = {16'd0, d};
      vals[CSR_TIME_STEP] = {16'd0, step};
      vals[CSR_INT_LOW] = ilo;
      vals[CSR_INT_HIGH] = ihi;
      vals[CSR_DRV_LOW] = {16'd0, dlo};
      vals[CSR_DRV_HIGH] = {16'd0, dhi};
      for (int r = 0; r < 8; r++) begin
         csr_we <= 1'b1;
         csr_index <= r[2:0];
         csr_wdata <= vals[r];
         case (r[2:0])
            CSR_GAIN_P:    kp = $signed(vals[r][15:0]);
            CSR_GAIN_I:    ki = $signed(vals[r][15:0]);
            CSR_GAIN_D:    kd_dt = $signed(vals[r][15:0]);
            CSR_TIME_STEP: dt_q16 = {48'd0, vals[r][15:0]};
            CSR_INT_LOW:   integ_lo = $signed(vals[r]);
            CSR_INT_HIGH:  integ_hi = $signed(vals[r]);
            CSR_DRV_LOW:   drv_lo = $signed(vals[r][15:0]);
            CSR_DRV_HIGH:  drv_hi = $signed(vals[r][15:0]);
            default: ;
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_regs();
      logic [15:0] step, dlo, dhi;
      logic [31:0] ilo, ihi;
      case ($urandom_range(0, 3))
         0: step = 16'd0;
         1: step = 16'hFFFF;
         2: step = 16'($urandom_range(1, 255));
         default: step = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: begin
            ilo = 32'h8000_0000;
            ihi = 32'h7FFF_FFFF;
         end
         1: begin
            // often crossed
            ilo = $urandom;
            ihi = $urandom;
         end
         default: begin
            ilo = -($urandom >> $urandom_range(1, 16));
            ihi = $urandom >> $urandom_range(1, 16);
         end
      endcase
      case ($urandom_range(0, 3))
         0: begin
            dlo = 16'h8000;
            dhi = 16'h7FFF;
         end
         1: begin
            dlo = 16'($urandom);
            dhi = 16'($urandom);
         end
         default: begin
            dlo = -16'($urandom_range(0, 32768));
            dhi = 16'($urandom_range(0, 32767));
         end
      endcase
      program_regs(pick16(), pick16(), pick16(), step, ilo, ihi, dlo, dhi);
   endtask

   // counts only beats that change state or produce a drive
   task automatic queue_random(input int count);
      int made, roll;
      logic [15:0] tgt, meas;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            tgt = pick16();
            // half the time a loop tracking its set point
            meas = $urandom_range(0, 1) ? tgt + 16'($urandom_range(0, 64)) - 16'd32
                                        : pick16();
            queue_beat(CMD_SAMPLE, tgt, meas, $urandom);
            made++;
         end else if (roll < 83) begin
            queue_beat(CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom);
            made++;
         end else if (roll < 95) begin
            queue_beat(CMD_PRELOAD, 16'($urandom), 16'($urandom), pick32());
            made++;
         end else begin
            queue_beat(CMD_UNUSED, 16'($urandom), 16'($urandom), $urandom);
         end
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_idling(1);

      // reset settings: zero gains, integral runs into its upper clamp
      queue_beat(CMD_SAMPLE, 16'h7FFF, 16'h8000, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
      wait_idle();

      program_regs(16'h0100, 16'h0080, 16'hFFC0, 16'h1000,
                   32'hFF9C_0000, 32'h0064_0000, 16'hFC18, 16'h03E8);
      queue_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h7FFF, 16'h8000, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h8000, 16'h7FFF, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 32'h0);
      queue_beat(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      queue_beat(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      // first sample after clear has no derivative kick
      queue_beat(CMD_SAMPLE, 16'h0064, 16'h0000, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h0032, 16'h0000, 32'h0);
      // preload bypasses the clamp; the next sample applies it
      queue_beat(CMD_PRELOAD, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
      queue_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 32'h0);
      queue_beat(CMD_PRELOAD, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
      queue_beat(CMD_SAMPLE, 16'h0001, 16'h0000, 32'h0);
      queue_beat(CMD_UNUSED, 16'h0000, 16'h0000, 32'h0);
      queue_beat(CMD_CLEAR, 16'h0000, 16'h0000, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h8000, 16'h8000, 32'h0);
      wait_idle();

      // extreme gains, zero time step
      set_idling(2);
      program_regs(16'h7FFF, 16'h8000, 16'h8000, 16'h0000,
                   32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF);
      queue_beat(CMD_PRELOAD, 16'h0000, 16'h0000, 32'h4000_0000);
      queue_beat(CMD_SAMPLE, 16'h7FFF, 16'h8000, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h8000, 16'h7FFF, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 32'h0);
      wait_idle();

      // crossed limits: the high limit wins
      set_idling(0);
      program_regs(16'h0200, 16'h0100, 16'h0100, 16'hFFFF,
                   32'h0005_0000, 32'hFFFB_0000, 16'h0064, 16'hFF9C);
      queue_beat(CMD_SAMPLE, 16'h0010, 16'h0000, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h0000, 16'h0010, 32'h0);
      queue_beat(CMD_SAMPLE, 16'h7FFF, 16'h8000, 32'h0);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         random_regs();
         set_idling(ph < 3 ? ph : $urandom_range(0, 2));
         queue_random(72);
         wait_idle();
      end

      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/pidc_pkg.sv
design/pidc_dp.sv
design/pidc_seq.sv
design/pid_controller_clamped.sv
design/pidc_checker.sv
verif/pid_controller_clamped_tb.sv
